// ===== sv/aep_pkg.sv =====
// aep_pkg: shared constants for animation_easing_progress
// used by aep_front, aep_back, the top level and the testbench; depends on nothing
package aep_pkg;

  localparam int TIME_WIDTH_DEF = 48;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int DUR_W          = 32;
  localparam int CURVE_W        = 3;

  localparam logic [CURVE_W-1:0] CURVE_LINEAR = 3'd0;
  localparam logic [CURVE_W-1:0] CURVE_SLOW   = 3'd1;
  localparam logic [CURVE_W-1:0] CURVE_FAST   = 3'd2;
  localparam logic [CURVE_W-1:0] CURVE_SSTEP  = 3'd3;
  localparam logic [CURVE_W-1:0] CURVE_RATL   = 3'd4;

endpackage

// ===== sv/aep_ram.sv =====
// aep_ram: generic single write, single registered read port memory
// depends on nothing
module aep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read, read data holds without re
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== sv/aep_div.sv =====
// aep_div: pipelined restoring divider, one quotient bit per stage
// quotient of n by d (d nonzero); side data travels alongside; no package use
module aep_div #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] side_out
);
  logic [DW:0]   rem  [NW+1];
  logic [NW-1:0] q    [NW+1];
  logic [NW-1:0] nm   [NW+1];
  logic [DW-1:0] dv   [NW+1];
  logic [SW-1:0] sd   [NW+1];
  logic          vl   [NW+1];

  assign rem[0] = '0;
  assign q[0]   = '0;
  assign nm[0]  = num;
  assign dv[0]  = den;
  assign sd[0]  = side_in;
  assign vl[0]  = in_valid;

  // one quotient bit per stage, msb first
  for (genvar i = 0; i < NW; i++) begin : g_stg
    logic [DW+1:0] sh;
    logic [DW+1:0] df;
    assign sh = {rem[i], nm[i][NW-1-i]};
    assign df = sh - {2'b00, dv[i]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else begin
        vl[i+1] <= vl[i];
      end
      rem[i+1] <= df[DW+1] ? sh[DW:0] : df[DW:0];
      q[i+1]   <= {q[i][NW-2:0], ~df[DW+1]};
      nm[i+1]  <= nm[i];
      dv[i+1]  <= dv[i];
      sd[i+1]  <= sd[i];
    end
  end

  assign out_valid = vl[NW];
  assign quo       = q[NW];
  assign side_out  = sd[NW];
endmodule

// ===== sv/aep_front.sv =====
// aep_front: accepts beats, computes elapsed time and linear progress
// uses aep_pkg and aep_div
module aep_front
  import aep_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [TIME_WIDTH-1:0] now_ms,
  input  logic [TIME_WIDTH-1:0] start_ms,
  input  logic [DUR_W-1:0]      duration_ms,
  input  logic [CURVE_W-1:0]    curve,
  input  logic                  first_update,
  output logic                  x_valid,
  output logic [FRAC_BITS:0]    x,
  output logic [CURVE_W-1:0]    x_curve
);
  localparam int NW = DUR_W + FRAC_BITS;
  localparam int SW = CURVE_W + 1;

  logic [TIME_WIDTH-1:0] elapsed;
  logic                  full_one;
  logic [NW-1:0]         num;
  logic [DUR_W-1:0]      den;
  logic                  s1_valid;
  logic [NW-1:0]         s1_num;
  logic [DUR_W-1:0]      s1_den;
  logic [SW-1:0]         s1_side;
  logic [NW-1:0]         quo;
  logic [SW-1:0]         side_q;

  // elapsed time and clamp test
  assign elapsed  = first_update ? '0 : (now_ms - start_ms);
  assign full_one = (duration_ms == '0) ||
                    ({{(DUR_W+TIME_WIDTH){1'b0}}, elapsed} >=
                     {{TIME_WIDTH{1'b0}}, {TIME_WIDTH{1'b0}}, duration_ms});
  // below the clamp elapsed is under the duration, so it fits DUR_W bits
  assign num = {DUR_W'(elapsed), {FRAC_BITS{1'b0}}};
  assign den = full_one ? {{(DUR_W-1){1'b0}}, 1'b1} : duration_ms;

  // register the division operands
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_num  <= num;
    s1_den  <= den;
    s1_side <= {full_one, curve};
  end

  aep_div #(.NW(NW), .DW(DUR_W), .SW(SW)) u_div (
    .clk(clk), .rst(rst), .in_valid(s1_valid), .num(s1_num), .den(s1_den),
    .side_in(s1_side), .out_valid(x_valid), .quo(quo), .side_out(side_q)
  );

  // clamp to one
  assign x       = side_q[SW-1] ? (FRAC_BITS+1)'(1) << FRAC_BITS : quo[FRAC_BITS:0];
  assign x_curve = side_q[CURVE_W-1:0];
endmodule

// ===== sv/aep_back.sv =====
// aep_back: applies the ease curve to linear progress, pipelined
// uses aep_pkg and aep_div
module aep_back
  import aep_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               x_valid,
  input  logic [FRAC_BITS:0] x,
  input  logic [CURVE_W-1:0] x_curve,
  output logic               p_valid,
  output logic [FRAC_BITS:0] p
);
  localparam int PW  = FRAC_BITS + 1;
  localparam int NW1 = 2*FRAC_BITS + 4;
  localparam int DW1 = FRAC_BITS + 3;
  localparam int NW2 = 2*FRAC_BITS + 2;
  localparam int DW2 = FRAC_BITS + 2;
  localparam logic [PW-1:0] ONE  = PW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS-1);
  // side bits: curve
  localparam int SW1 = CURVE_W;

  // stage a: base and square
  logic               a_valid;
  logic [PW-1:0]      a_base, a_x, a_lin;
  logic [CURVE_W-1:0] a_curve;
  logic [PW-1:0]      b_sq;
  logic               b_valid;
  logic [PW-1:0]      b_base, b_x, b_lin;
  logic [CURVE_W-1:0] b_curve;
  logic [2*PW-1:0]    sq_full;
  logic [PW:0]        b_mul;
  logic [2*PW+1:0]    m2_full;
  logic               c_valid;
  logic [PW-1:0]      c_poly, c_lin;
  logic [CURVE_W-1:0] c_curve;
  logic [PW-1:0]      c_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= x_valid;
    end
    a_base  <= (x_curve == CURVE_SLOW) ? ONE - x : x;
    a_x     <= x;
    a_lin   <= x;
    a_curve <= x_curve;
  end

  assign sq_full = a_base * a_base;
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_sq    <= sq_full[FRAC_BITS +: PW];
    b_base  <= a_base;
    b_x     <= a_x;
    b_lin   <= a_lin;
    b_curve <= a_curve;
  end

  // second product: cube or smoothstep factor
  assign b_mul   = (b_curve == CURVE_SSTEP) ? (PW+1)'(3*(2**FRAC_BITS)) - {b_x, 1'b0}
                                            : {1'b0, b_base};
  assign m2_full = {{(PW+1){1'b0}}, b_sq} * {{PW{1'b0}}, b_mul};
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
    c_poly  <= m2_full[FRAC_BITS +: PW];
    c_lin   <= b_lin;
    c_curve <= b_curve;
  end

  always_comb begin
    case (c_curve)
      CURVE_SLOW:  c_res = ONE - c_poly;
      CURVE_FAST:  c_res = c_poly;
      CURVE_SSTEP: c_res = c_poly;
      default:     c_res = c_lin;
    endcase
  end

  // rational path: r = 3x*ONE/(2*ONE+x)
  logic            r_valid;
  logic [NW1-1:0]  r_q;
  logic [SW1-1:0]  r_side;
  logic [NW1-1:0]  r_num;
  logic [DW1-1:0]  r_den;
  assign r_num = NW1'(3 * {{(NW1-PW){1'b0}}, x}) << FRAC_BITS;
  assign r_den = DW1'({ONE, 1'b0}) + DW1'(x);

  aep_div #(.NW(NW1), .DW(DW1), .SW(SW1)) u_div1 (
    .clk(clk), .rst(rst), .in_valid(x_valid), .num(r_num), .den(r_den),
    .side_in(x_curve), .out_valid(r_valid), .quo(r_q),
    .side_out(r_side)
  );

  // d = 2r - ONE, u = |d|
  logic [PW+1:0]   tw;
  logic            pos, sat;
  logic [PW-1:0]   u;
  logic            u_valid, u_pos, u_sat, u_top;
  logic [PW-1:0]   u_v;
  logic [CURVE_W-1:0] u_curve;
  assign tw  = {r_q[PW:0], 1'b0};
  assign pos = tw >= (PW+2)'(ONE);
  assign sat = pos ? (tw - (PW+2)'(ONE)) >= (PW+2)'(ONE) : 1'b0;
  assign u   = pos ? PW'(tw - (PW+2)'(ONE)) : PW'((PW+2)'(ONE) - tw);

  always_ff @(posedge clk) begin
    if (rst) begin
      u_valid <= 1'b0;
    end else begin
      u_valid <= r_valid;
    end
    u_pos   <= pos;
    u_sat   <= sat;
    u_top   <= tw > (PW+2)'(ONE);
    u_v     <= u;
    u_curve <= r_side;
  end

  // u*u/ONE
  logic [2*PW-1:0] uu;
  logic            w_valid, w_pos, w_sat, w_top;
  logic [PW-1:0]   w_u, w_sq;
  logic [CURVE_W-1:0] w_curve;
  assign uu = u_v * u_v;
  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
    end else begin
      w_valid <= u_valid;
    end
    w_pos   <= u_pos;
    w_sat   <= u_sat;
    w_top   <= u_top;
    w_u     <= u_v;
    w_sq    <= uu[FRAC_BITS +: PW];
    w_curve <= u_curve;
  end

  logic [NW2-1:0] q_num;
  logic [DW2-1:0] q_den;
  logic           q_valid;
  logic [NW2-1:0] q_q;
  logic [CURVE_W+2:0] q_side;
  assign q_num = NW2'(w_u) << FRAC_BITS;
  assign q_den = DW2'(ONE) + DW2'(w_sq);

  aep_div #(.NW(NW2), .DW(DW2), .SW(CURVE_W+3)) u_div2 (
    .clk(clk), .rst(rst), .in_valid(w_valid), .num(q_num), .den(q_den),
    .side_in({w_curve, w_pos, w_sat, w_top}), .out_valid(q_valid),
    .quo(q_q), .side_out(q_side)
  );

  logic [PW-1:0] rat;
  always_comb begin
    if (q_side[1]) begin
      rat = q_side[0] ? ONE : '0;
    end else if (q_side[2]) begin
      rat = HALF + q_q[PW-1:0];
    end else begin
      rat = HALF - q_q[PW-1:0];
    end
  end

  // align polynomial path to rational latency with a delay line
  localparam int DLY = NW1 + 2 + NW2 - 3;
  logic [PW-1:0]      dl_v [DLY+1];
  logic [CURVE_W-1:0] dl_c [DLY+1];
  assign dl_v[0] = c_res;
  assign dl_c[0] = c_curve;
  for (genvar i = 0; i < DLY; i++) begin : g_dl
    always_ff @(posedge clk) begin
      dl_v[i+1] <= dl_v[i];
      dl_c[i+1] <= dl_c[i];
    end
  end

  assign p_valid = q_valid;
  assign p = (dl_c[DLY] == CURVE_RATL) ? rat : dl_v[DLY];

`ifndef NO_ASSERTIONS
  a_curve_align: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (q_side[CURVE_W+2:3] == dl_c[DLY]))
    else $error("curve misaligned between paths");
  a_prog_range: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (p <= ONE))
    else $error("progress above one");
  a_valid_chain: assert property (@(posedge clk) disable iff (rst)
    c_valid |=> ##(DLY-1) q_valid)
    else $error("valid chain lost");
`endif
endmodule

// ===== sv/animation_easing_progress.sv =====
// animation_easing_progress: top level, pipelined front, result queue
// uses aep_pkg, aep_front, aep_back and aep_ram
//
// usage:
//  input channel: push, full. a beat enters when push is high and full is
//  low; fields now_ms, start_ms, duration_ms, curve, first_update.
//  result channel: empty, pop. progress and finished show the oldest
//  result while empty is low; it leaves when pop is high and empty is low.
//  throughput: one beat per cycle while full is low. a result passes an
//  operand register and 32 + FRAC_BITS front divider stages, then
//  4*FRAC_BITS + 8 back stages (two dividers and two registers), then
//  the queue write and its registered read.
//  the pipeline never stalls; a credit count of beats accepted and not
//  yet popped raises full at the queue depth of 256, so a stalled
//  receiver only stops new beats, never drops results.
//  reset (rst, synchronous) empties the pipeline and queue; no clearing
//  pass is needed.
module animation_easing_progress
  import aep_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [TIME_WIDTH-1:0] now_ms,
  input  logic [TIME_WIDTH-1:0] start_ms,
  input  logic [DUR_W-1:0]      duration_ms,
  input  logic [CURVE_W-1:0]    curve,
  input  logic                  first_update,
  output logic                  empty,
  input  logic                  pop,
  output logic [FRAC_BITS:0]    progress,
  output logic                  finished
);
  localparam int PW    = FRAC_BITS + 1;
  localparam int QD    = 256;
  localparam int AW    = $clog2(QD);
  localparam int CW    = AW + 1;

  logic               acc, deq;
  logic               x_valid, p_valid;
  logic [FRAC_BITS:0] x, p;
  logic [CURVE_W-1:0] x_curve;

  assign acc = push & ~full;

  aep_front #(.TIME_WIDTH(TIME_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(acc), .now_ms(now_ms), .start_ms(start_ms),
    .duration_ms(duration_ms), .curve(curve), .first_update(first_update),
    .x_valid(x_valid), .x(x), .x_curve(x_curve)
  );

  aep_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .x_valid(x_valid), .x(x), .x_curve(x_curve),
    .p_valid(p_valid), .p(p)
  );

  // result queue with credit count covering beats in flight
  logic [AW-1:0] wp, rp;
  logic [CW-1:0] stored;
  logic [CW-1:0] credits;
  logic          out_v;
  logic [PW-1:0] rdata;
  logic          rd;
  logic [AW-1:0] rp_next;

  assign full  = (credits == CW'(QD));
  assign empty = ~out_v;
  assign deq   = pop & out_v;
  assign rd    = (stored != '0) && (~out_v || deq);
  assign rp_next = rd ? rp + AW'(1) : rp;

  aep_ram #(.WIDTH(PW), .DEPTH(QD)) u_ram (
    .clk(clk), .we(p_valid), .waddr(wp), .wdata(p), .re(rd), .raddr(rp),
    .rdata(rdata)
  );

  // pointers and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      rp      <= '0;
      stored  <= '0;
      credits <= '0;
      out_v   <= 1'b0;
    end else begin
      if (p_valid) begin
        wp <= wp + AW'(1);
      end
      rp      <= rp_next;
      stored  <= stored + CW'(p_valid) - CW'(rd);
      credits <= credits + CW'(acc) - CW'(deq);
      if (rd) begin
        out_v <= 1'b1;
      end else if (deq) begin
        out_v <= 1'b0;
      end
    end
  end

  assign progress = rdata;
  assign finished = (rdata == (PW'(1) << FRAC_BITS));

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (stored != CW'(QD)))
    else $error("result queue overflow");
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credits <= CW'(QD))
    else $error("credit count beyond depth");
  a_stored_le_credit: assert property (@(posedge clk) disable iff (rst)
    stored <= credits)
    else $error("stored beyond credits");
`endif
endmodule

// ===== verif/aep_checker.sv =====
`timescale 1ns / 1ps
// aep_checker: watches the input and result channels of animation_easing_progress,
// predicts eased progress per accepted beat and compares results in order; uses aep_pkg
module aep_checker
  import aep_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic                      full,
  input  logic [TIME_WIDTH_DEF-1:0] now_ms,
  input  logic [TIME_WIDTH_DEF-1:0] start_ms,
  input  logic [DUR_W-1:0]          duration_ms,
  input  logic [CURVE_W-1:0]        curve,
  input  logic                      first_update,
  input  logic                      empty,
  input  logic                      pop,
  input  logic [FRAC_BITS_DEF:0]    progress,
  input  logic                      finished,
  output int                        fail_count,
  output int                        pending,
  output int                        beats_in,
  output int                        beats_out
);

  localparam logic [63:0] ONE  = 64'd1 << FRAC_BITS_DEF;
  localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS_DEF - 1);

  typedef struct packed {
    logic [FRAC_BITS_DEF:0] prog;
    logic                   done;
  } ease_result_t;

  ease_result_t ease_q[$];

  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> FRAC_BITS_DEF;
  endfunction

  // rational curve 3x/(x+2) reshaped around one half
  function automatic logic [63:0] rational_ease(input logic [63:0] x);
    logic [63:0] r, tw, u, q;
    logic        up;
    r  = (64'd3 * x * ONE) / (64'd2 * ONE + x);
    tw = 64'd2 * r;
    up = tw >= ONE;
    u  = up ? tw - ONE : ONE - tw;
    if (u >= ONE) return (up && tw > ONE) ? ONE : 64'd0;
    q = (u * ONE) / (ONE + fx_mul(u, u));
    return up ? HALF + q : HALF - q;
  endfunction

  function automatic ease_result_t predict_ease(
    input logic [TIME_WIDTH_DEF-1:0] t_now, input logic [TIME_WIDTH_DEF-1:0] t_start,
    input logic [DUR_W-1:0] dur, input logic [CURVE_W-1:0] sel, input logic first);
    logic [TIME_WIDTH_DEF-1:0] elapsed;
    logic [63:0]               x, p, inv;
    ease_result_t              res;
    elapsed = first ? '0 : t_now - t_start;
    if (dur == 0 || {16'd0, elapsed} >= {32'd0, dur}) x = ONE;
    else x = ({16'd0, elapsed} * ONE) / {32'd0, dur};
    inv = ONE - x;
    case (sel)
      CURVE_SLOW:  p = ONE - fx_mul(fx_mul(inv, inv), inv);
      CURVE_FAST:  p = fx_mul(fx_mul(x, x), x);
      CURVE_SSTEP: p = fx_mul(fx_mul(x, x), 64'd3 * ONE - 64'd2 * x);
      CURVE_RATL:  p = rational_ease(x);
      default:     p = x;
    endcase
    res.prog = p[FRAC_BITS_DEF:0];
    res.done = (p == ONE);
    return res;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("beat %0d: %s got %0d expected %0d", beats_out, what, got, want);
    fail_count++;
  endtask

  assign pending = ease_q.size();

  // predict on input beats, compare on result beats
  always @(posedge clk) begin
    ease_result_t want;
    if (rst) begin
      fail_count <= 0;
      beats_in   <= 0;
      beats_out  <= 0;
    end else begin
      if (push && !full) begin
        ease_q.push_back(predict_ease(now_ms, start_ms, duration_ms, curve, first_update));
        beats_in <= beats_in + 1;
      end
      if (pop && !empty) begin
        if (ease_q.size() == 0) begin
          report("unexpected result, progress", 32'(progress), 32'd0);
        end else begin
          want = ease_q.pop_front();
          if (progress !== want.prog)
            report("progress", 32'(progress), 32'(want.prog));
          if (finished !== want.done)
            report("finished", 32'(finished), 32'(want.done));
        end
        beats_out <= beats_out + 1;
      end
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// tb: stimulus and verdict for animation_easing_progress
// uses aep_pkg, the block and aep_checker
module tb;
  import aep_pkg::*;

  localparam int N_RANDOM  = 1630;
  localparam int WDOG_MAX  = 20000;
  localparam int HOLD_LEN  = 1500;

  logic                      clk = 0;
  logic                      rst = 1;
  logic                      push = 0;
  logic                      pop = 0;
  logic [TIME_WIDTH_DEF-1:0] now_ms = '0;
  logic [TIME_WIDTH_DEF-1:0] start_ms = '0;
  logic [DUR_W-1:0]          duration_ms = '0;
  logic [CURVE_W-1:0]        curve = CURVE_LINEAR;
  logic                      first_update = 0;
  logic                      full, empty, finished;
  logic [FRAC_BITS_DEF:0]    progress;
  int                        fail_count, pending, beats_in, beats_out;
  int                        wdog;
  bit                        quiet_tail = 0;
  bit                        stim_done = 0;

  always #5 clk = ~clk;

  animation_easing_progress dut (
    .clk, .rst, .push, .full, .now_ms, .start_ms, .duration_ms, .curve,
    .first_update, .empty, .pop, .progress, .finished
  );

  aep_checker chk (
    .clk, .rst, .push, .full, .now_ms, .start_ms, .duration_ms, .curve,
    .first_update, .empty, .pop, .progress, .finished,
    .fail_count, .pending, .beats_in, .beats_out
  );

  // offer one beat and wait until it is taken
  task automatic send_beat(input logic [TIME_WIDTH_DEF-1:0] t_now,
                           input logic [TIME_WIDTH_DEF-1:0] t_start,
                           input logic [DUR_W-1:0] dur,
                           input logic [CURVE_W-1:0] sel, input logic first);
    push         <= 1;
    now_ms       <= t_now;
    start_ms     <= t_start;
    duration_ms  <= dur;
    curve        <= sel;
    first_update <= first;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic maybe_gap();
    int n;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 19);
      push <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  // mostly durations that give a spread of progress, some full-range
  task automatic random_beat();
    logic [47:0] t0, el;
    logic [31:0] dur;
    logic [CURVE_W-1:0] sel;
    sel = $urandom_range(0, 9) == 0 ? CURVE_W'($urandom_range(5, 7))
                                    : CURVE_W'($urandom_range(0, 4));
    t0 = rand48();
    case ($urandom_range(0, 5))
      0: dur = $urandom();
      1: dur = $urandom_range(0, 3);
      default: dur = $urandom_range(1, 100000);
    endcase
    case ($urandom_range(0, 5))
      0: el = rand48();
      1: el = {16'd0, dur} + 48'($urandom_range(0, 2));
      default: el = dur == 0 ? 48'd0 : {16'd0, $urandom_range(0, dur)};
    endcase
    send_beat(t0 + el, t0, dur, sel, $urandom_range(0, 15) == 0);
  endtask

  // stimulus
  initial begin
    logic [CURVE_W-1:0] c;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, every curve, wrap, first update, zero duration
    for (int i = 0; i < 8; i++) begin
      c = CURVE_W'(i);
      send_beat(48'd500, 48'd0, 32'd1000, c, 0);
    end
    send_beat('1, '0, '1, CURVE_SLOW, 0);
    send_beat('0, '1, 32'd10, CURVE_LINEAR, 0);
    send_beat(48'd5, 48'd9, '1, CURVE_RATL, 0);
    send_beat(48'd77, 48'd3, 32'd0, CURVE_SSTEP, 1);
    send_beat(48'd77, 48'd3, 32'd100, CURVE_FAST, 1);
    send_beat('1, '1, 32'd1, CURVE_RATL, 0);
    send_beat(48'd99, 48'd0, 32'd100, CURVE_RATL, 0);
    send_beat(48'd1, 48'd0, '1, CURVE_SSTEP, 0);
    send_beat(48'd0, 48'd0, 32'd0, CURVE_LINEAR, 0);
    send_beat(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 32'hAAAA_AAAA, 3'd7, 0);
    send_beat(48'h5555_5555_5555, 48'h0, 32'h5555_5555, CURVE_SLOW, 0);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i > N_RANDOM - 150) quiet_tail = 1;
      random_beat();
      maybe_gap();
    end
    push <= 0;
    stim_done = 1;
  end

  // receiver: one long hold early on, then random stalls
  initial begin
    int n;
    pop <= 0;
    wait (!rst);
    repeat (HOLD_LEN) @(posedge clk);
    forever begin
      pop <= 1;
      @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 19);
        pop <= 0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // watchdog and verdict
  initial begin
    wdog = 0;
    wait (!rst);
    while (!(stim_done && pending == 0)) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) wdog = 0;
      else wdog++;
      if (wdog >= WDOG_MAX) begin
        $display("timeout after %0d idle cycles", wdog);
        $display("animation_easing_progress: mismatch");
        $finish;
      end
    end
    repeat (200) @(posedge clk);
    $display("sent %0d beats over all curves, zero and wrapped durations, first updates;",
             beats_in);
    $display("checked %0d results with random stalls and a long receiver hold", beats_out);
    if (fail_count == 0 && pending == 0 && empty)
      $display("animation_easing_progress: match");
    else
      $display("animation_easing_progress: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/aep_pkg.sv
sv/aep_ram.sv
sv/aep_div.sv
sv/aep_front.sv
sv/aep_back.sv
sv/animation_easing_progress.sv
verif/aep_checker.sv
verif/tb.sv
